@@ hdl/mesh_feature_edge_table_core_defines.svh @@
// Assertion macros for the mesh feature edge table
`ifndef MESH_FEATURE_EDGE_TABLE_CORE_DEFINES_SVH
`define MESH_FEATURE_EDGE_TABLE_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MFET_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define MFET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/mfet_pkg.sv @@
// Types and constants shared by the mesh feature edge table
`timescale 1ns / 1ps
package mfet_pkg;

    localparam int INDEX_BITS  = 16;
    localparam int NORMAL_BITS = 16;
    localparam int FRAC_BITS   = NORMAL_BITS - 1;
    localparam int COS_BITS    = 16;
    localparam int COUNT_BITS  = 11;
    localparam int SLOT_IN_BITS = 10;
    localparam int PROD_BITS   = 2 * NORMAL_BITS;
    localparam int DOT_BITS    = PROD_BITS + 2;
    localparam int CMP_BITS    = DOT_BITS + COS_BITS + 2 * FRAC_BITS;

    localparam logic [31:0] HASH_MUL_LO = 32'd2654435761;
    localparam logic [31:0] HASH_MUL_HI = 32'd40503;
    localparam logic signed [COS_BITS-1:0] COS_RESET = 16'sd28378;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_DROPPED = 2'd1,
        STAT_SLOT    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_ADDR,
        S_CHECK,
        S_DOT,
        S_RDSLOT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                          valid;
        logic                          feature;
        logic [1:0]                    faces;
        logic signed [NORMAL_BITS-1:0] nz;
        logic signed [NORMAL_BITS-1:0] ny;
        logic signed [NORMAL_BITS-1:0] nx;
        logic [INDEX_BITS-1:0]         hi;
        logic [INDEX_BITS-1:0]         lo;
    } t_slot;

endpackage

@@ hdl/mesh_feature_edge_table_core.sv @@
// Mesh feature edge table: hashed edge store with linear probing and crease test
// Steps: an add hashes, reads and checks each edge, with a further check for each extra probe
//   and a dot-product step when a second face arrives; a read fetches one slot; a clear sweeps every slot.
// Flow: one item at a time; the next word is taken once the result word has been issued.
// Reset: synchronous, active low; afterwards a clearing pass sweeps every table slot
//   before the first item is taken.
`timescale 1ns / 1ps
`include "mesh_feature_edge_table_core_defines.svh"
module mesh_feature_edge_table_core #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // vertex_a, vertex_b, vertex_c, normal_x, normal_y, normal_z, slot_index, pad
    input  logic [111:0] i_s_axis_tdata,
    // command
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // slot_used, slot_is_feature, edge_low_index, edge_high_index, face_count,
    // feature_count, pad
    output logic [47:0]  o_m_axis_tdata,
    // status
    output logic [1:0]   o_m_axis_tuser
);

    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
    localparam int IB = mfet_pkg::INDEX_BITS;
    localparam int NB = mfet_pkg::NORMAL_BITS;
    localparam int SLOT_IN_W = mfet_pkg::SLOT_IN_BITS;

    mfet_pkg::t_slot r_mem [TABLE_SLOTS];
    mfet_pkg::t_slot r_rd_data;

    mfet_pkg::t_state r_state, n_state;
    mfet_pkg::t_cmd   r_cmd;

    logic signed [mfet_pkg::COS_BITS-1:0] r_cos;
    logic [IB-1:0] r_va, r_vb, r_vc, r_lo, r_hi;
    logic signed [NB-1:0] r_nx, r_ny, r_nz;
    logic [SLOT_IN_W-1:0] r_slot_in;
    logic [1:0]  r_edge;
    logic [31:0] r_ha, r_hb;
    logic [SLOT_BITS-1:0] r_idx, r_sweep;
    logic [SLOT_BITS:0]   r_probe;
    logic        r_drop;
    logic [mfet_pkg::COUNT_BITS-1:0] r_feat_total;
    logic signed [mfet_pkg::PROD_BITS-1:0] r_px, r_py, r_pz;

    logic                 mem_we, rd_en;
    logic [SLOT_BITS-1:0] mem_wa, rd_addr;
    mfet_pkg::t_slot      mem_wd;
    logic                 feat_up, feat_dn;
    logic [IB-1:0]        sel_p, sel_q;
    logic                 hit, crease;
    logic signed [mfet_pkg::DOT_BITS-1:0] dot;
    logic signed [mfet_pkg::CMP_BITS-1:0] lhs, rhs;
    logic                 out_free, probe_last, sweep_last;
    logic [47:0]          out_data;
    logic [1:0]           out_user;

    assign out_free   = !o_m_axis_tvalid || i_m_axis_tready;
    assign probe_last = (r_probe == (SLOT_BITS+1)'(TABLE_SLOTS - 1));
    assign sweep_last = (r_sweep == SLOT_BITS'(TABLE_SLOTS - 1));
    assign hit        = (r_rd_data.lo == r_lo) && (r_rd_data.hi == r_hi);
    assign o_s_axis_tready = (r_state == mfet_pkg::S_IDLE);

    always_comb begin
        case (r_edge)
            2'd0:    begin sel_p = r_va; sel_q = r_vb; end
            2'd1:    begin sel_p = r_vb; sel_q = r_vc; end
            default: begin sel_p = r_vc; sel_q = r_va; end
        endcase
    end

    // exact crease compare: dot * 2^15 < cosine * 2^(2*frac)
    assign dot = mfet_pkg::DOT_BITS'(r_px) + mfet_pkg::DOT_BITS'(r_py)
               + mfet_pkg::DOT_BITS'(r_pz);
    assign lhs = mfet_pkg::CMP_BITS'(dot) <<< 15;
    assign rhs = mfet_pkg::CMP_BITS'(r_cos) <<< (2 * mfet_pkg::FRAC_BITS);
    assign crease = (lhs < rhs);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mfet_pkg::S_SWEEP: if (sweep_last) begin
                n_state = (r_cmd == mfet_pkg::CMD_CLEAR) ? mfet_pkg::S_DONE
                                                         : mfet_pkg::S_IDLE;
            end
            mfet_pkg::S_IDLE: if (i_s_axis_tvalid) begin
                unique case (mfet_pkg::t_cmd'(i_s_axis_tuser))
                    mfet_pkg::CMD_CLEAR: n_state = mfet_pkg::S_SWEEP;
                    mfet_pkg::CMD_ADD:   n_state = mfet_pkg::S_HASH;
                    mfet_pkg::CMD_READ:  n_state = mfet_pkg::S_RDSLOT;
                    default:             n_state = mfet_pkg::S_DONE;
                endcase
            end
            mfet_pkg::S_HASH:   n_state = mfet_pkg::S_ADDR;
            mfet_pkg::S_ADDR:   n_state = mfet_pkg::S_CHECK;
            mfet_pkg::S_CHECK: begin
                if (!r_rd_data.valid || (hit && r_rd_data.faces != 2'd1) ||
                    (!hit && probe_last)) begin
                    n_state = (r_edge == 2'd2) ? mfet_pkg::S_DONE : mfet_pkg::S_HASH;
                end else if (hit) begin
                    n_state = mfet_pkg::S_DOT;
                end
            end
            mfet_pkg::S_DOT:
                n_state = (r_edge == 2'd2) ? mfet_pkg::S_DONE : mfet_pkg::S_HASH;
            mfet_pkg::S_RDSLOT: n_state = mfet_pkg::S_DONE;
            mfet_pkg::S_DONE:   if (out_free) n_state = mfet_pkg::S_IDLE;
            default:            n_state = mfet_pkg::S_IDLE;
        endcase
    end

    // table access and count updates
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_idx;
        mem_wd  = r_rd_data;
        rd_en   = 1'b0;
        rd_addr = r_idx;
        feat_up = 1'b0;
        feat_dn = 1'b0;
        unique case (r_state)
            mfet_pkg::S_SWEEP: begin
                mem_we       = 1'b1;
                mem_wa       = r_sweep;
                mem_wd       = '0;
            end
            mfet_pkg::S_ADDR: begin
                rd_en   = 1'b1;
                rd_addr = SLOT_BITS'(r_ha ^ r_hb);
            end
            mfet_pkg::S_CHECK: begin
                if (!r_rd_data.valid) begin
                    mem_we  = 1'b1;
                    mem_wd  = '{valid: 1'b1, feature: 1'b1, faces: 2'd1,
                                nz: r_nz, ny: r_ny, nx: r_nx, hi: r_hi, lo: r_lo};
                    feat_up = 1'b1;
                end else if (hit) begin
                    if (r_rd_data.faces != 2'd1) begin
                        mem_we          = 1'b1;
                        mem_wd.faces    = 2'd2;
                        mem_wd.feature  = 1'b1;
                        feat_up         = !r_rd_data.feature;
                    end
                end else if (!probe_last) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + 1'b1;
                end
            end
            mfet_pkg::S_DOT: begin
                mem_we         = 1'b1;
                mem_wd.faces   = 2'd2;
                mem_wd.feature = crease;
                feat_up        = !r_rd_data.feature && crease;
                feat_dn        = r_rd_data.feature && !crease;
            end
            mfet_pkg::S_RDSLOT: begin
                rd_en   = 1'b1;
                rd_addr = SLOT_BITS'(r_slot_in);
            end
            default: ;
        endcase
    end

    // result word
    always_comb begin
        out_data        = '0;
        out_data[46:36] = r_feat_total;
        out_user        = mfet_pkg::STAT_DONE;
        if (r_cmd == mfet_pkg::CMD_ADD && r_drop) begin
            out_user = mfet_pkg::STAT_DROPPED;
        end
        if (r_cmd == mfet_pkg::CMD_READ) begin
            out_user = mfet_pkg::STAT_SLOT;
            if (r_rd_data.valid) begin
                out_data[0]     = 1'b1;
                out_data[1]     = r_rd_data.feature;
                out_data[17:2]  = r_rd_data.lo;
                out_data[33:18] = r_rd_data.hi;
                out_data[35:34] = r_rd_data.faces;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (rd_en)  r_rd_data     <= r_mem[rd_addr];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= mfet_pkg::S_SWEEP;
            r_cmd           <= mfet_pkg::CMD_NOP;
            r_sweep         <= '0;
            r_feat_total    <= '0;
            r_cos           <= mfet_pkg::COS_RESET;
            o_m_axis_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_cos <= i_cfg_wr_data;
            if (r_state == mfet_pkg::S_SWEEP) r_sweep <= r_sweep + 1'b1;
            if (o_s_axis_tready && i_s_axis_tvalid) begin
                r_cmd <= mfet_pkg::t_cmd'(i_s_axis_tuser);
                if (mfet_pkg::t_cmd'(i_s_axis_tuser) == mfet_pkg::CMD_CLEAR) begin
                    r_feat_total <= '0;
                end
            end else if (feat_up) begin
                r_feat_total <= r_feat_total + 1'b1;
            end else if (feat_dn) begin
                r_feat_total <= r_feat_total - 1'b1;
            end
            if (r_state == mfet_pkg::S_DONE && out_free) begin
                o_m_axis_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                o_m_axis_tvalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_va      <= i_s_axis_tdata[15:0];
            r_vb      <= i_s_axis_tdata[31:16];
            r_vc      <= i_s_axis_tdata[47:32];
            r_nx      <= i_s_axis_tdata[63:48];
            r_ny      <= i_s_axis_tdata[79:64];
            r_nz      <= i_s_axis_tdata[95:80];
            r_slot_in <= i_s_axis_tdata[105:96];
            r_edge    <= 2'd0;
            r_drop    <= 1'b0;
        end
        if (r_state == mfet_pkg::S_HASH) begin
            r_lo <= (sel_p < sel_q) ? sel_p : sel_q;
            r_hi <= (sel_p < sel_q) ? sel_q : sel_p;
            r_ha <= 32'(((sel_p < sel_q) ? sel_p : sel_q) * mfet_pkg::HASH_MUL_LO);
            r_hb <= 32'(((sel_p < sel_q) ? sel_q : sel_p) * mfet_pkg::HASH_MUL_HI);
        end
        if (r_state == mfet_pkg::S_ADDR) begin
            r_idx   <= rd_addr;
            r_probe <= '0;
        end
        if (r_state == mfet_pkg::S_CHECK) begin
            r_px <= r_rd_data.nx * r_nx;
            r_py <= r_rd_data.ny * r_ny;
            r_pz <= r_rd_data.nz * r_nz;
            if (rd_en) begin
                r_idx   <= rd_addr;
                r_probe <= r_probe + 1'b1;
            end
            if (r_rd_data.valid && !hit && probe_last) r_drop <= 1'b1;
        end
        // advance to the next edge once this one is settled
        if ((r_state == mfet_pkg::S_CHECK || r_state == mfet_pkg::S_DOT) &&
            n_state == mfet_pkg::S_HASH) begin
            r_edge <= r_edge + 1'b1;
        end
        if (r_state == mfet_pkg::S_DONE && out_free) begin
            o_m_axis_tdata <= out_data;
            o_m_axis_tuser <= out_user;
        end
    end

    `MFET_ASSERT_NOW(a_no_rw_clash, mem_we && rd_en, mem_wa != rd_addr, "table read and write hit one slot")
    `MFET_ASSERT_NOW(a_sweep_count, r_state == mfet_pkg::S_SWEEP && r_cmd == mfet_pkg::CMD_CLEAR, r_feat_total == '0, "feature count live during clear")
    `MFET_ASSERT_NEXT(a_done_emits, r_state == mfet_pkg::S_DONE && out_free, o_m_axis_tvalid, "finished item produced no word")

endmodule
